// ===== hw/rtl/tsqc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tsqc_pkg
// Types and codes shared by the two-stack queue checker.
// ----------------------------------------------------------------------------
package tsqc_pkg;

	localparam int FUNC_W  = 2;
	localparam int DATA_W  = 32;
	localparam int STAT_W  = 3;
	localparam int COUNT_W = 10;

	localparam logic [FUNC_W-1:0] FUNC_PUSH  = 2'd0;
	localparam logic [FUNC_W-1:0] FUNC_POP   = 2'd1;
	localparam logic [FUNC_W-1:0] FUNC_CHECK = 2'd2;

	localparam logic [STAT_W-1:0] ST_OK        = 3'd0;
	localparam logic [STAT_W-1:0] ST_MISMATCH  = 3'd1;
	localparam logic [STAT_W-1:0] ST_EMPTY_POP = 3'd2;
	localparam logic [STAT_W-1:0] ST_NOT_EMPTY = 3'd3;
	localparam logic [STAT_W-1:0] ST_FULL      = 3'd4;

	typedef struct packed {
		logic [FUNC_W-1:0]        func;
		logic signed [DATA_W-1:0] value;
	} cmd_t;

	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [DATA_W-1:0] popped_value;
		logic [COUNT_W-1:0]       entry_count;
		logic                     all_ok;
	} rsp_t;

endpackage

// ===== hw/rtl/two_stack_queue_checker.sv =====
`timescale 1ns / 1ps
// Order: push and check pass the execute and result states after acceptance; a pop
// from a non-empty outbound stack also passes the compare state, and a pop that needs a transfer
// first moves every inbound entry (one inbound memory read per entry moved), then executes again.
// A new command is taken only in the idle state, once the previous response has been loaded.
// Reset: counts, failure flag and control clear at once; stack memories are
// not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
// two_stack_queue_checker
// FIFO queue made of an inbound and an outbound stack held in two
// synchronous memories; checks popped values against expected ones.
// ----------------------------------------------------------------------------
module two_stack_queue_checker #(
	parameter int STACK_DEPTH = 256
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           cmd_valid,
	output logic           cmd_stall,
	input  tsqc_pkg::cmd_t cmd,
	output logic           rsp_valid,
	input  logic           rsp_stall,
	output tsqc_pkg::rsp_t rsp
);
	import tsqc_pkg::*;

	localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
	localparam int CW = AW + 1;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_EXEC = 3'd1;
	localparam logic [2:0] S_XFER = 3'd2;
	localparam logic [2:0] S_CMP  = 3'd3;
	localparam logic [2:0] S_RESP = 3'd4;

	logic [2:0]        state_q;
	logic [FUNC_W-1:0] func_q;
	logic [DATA_W-1:0] value_q;
	logic [STAT_W-1:0] status_q;
	logic [DATA_W-1:0] popped_q;
	logic [CW-1:0]     in_cnt_q;
	logic [CW-1:0]     out_cnt_q;
	logic              failure_q;
	logic              mv_pend_s1;
	logic              rsp_valid_q;
	rsp_t              rsp_q;

	logic [DATA_W-1:0] ibuf [STACK_DEPTH];
	logic [DATA_W-1:0] obuf [STACK_DEPTH];
	logic [DATA_W-1:0] ird_q;
	logic [DATA_W-1:0] ord_q;

	logic          ibuf_we, ibuf_re, obuf_we, obuf_re;
	logic [AW-1:0] ibuf_waddr, ibuf_raddr, obuf_waddr, obuf_raddr;
	logic [CW-1:0] in_dec, out_dec;
	logic [CW:0]   total;
	logic          in_full, q_empty, cmd_acc, rsp_load;

	assign in_dec   = in_cnt_q - CW'(1);
	assign out_dec  = out_cnt_q - CW'(1);
	assign total    = {1'b0, in_cnt_q} + {1'b0, out_cnt_q};
	assign in_full  = (in_cnt_q == CW'(STACK_DEPTH));
	assign q_empty  = (total == '0);
	assign cmd_stall = (state_q != S_IDLE);
	assign cmd_acc  = cmd_valid && !cmd_stall;
	assign rsp_load = (state_q == S_RESP) && (!rsp_valid_q || !rsp_stall);

	always_comb begin
		ibuf_we    = (state_q == S_EXEC) && (func_q == FUNC_PUSH) && !in_full;
		ibuf_waddr = in_cnt_q[AW-1:0];
		ibuf_re    = (state_q == S_XFER) && (in_cnt_q != '0);
		ibuf_raddr = in_dec[AW-1:0];
		obuf_we    = (state_q == S_XFER) && mv_pend_s1;
		obuf_waddr = out_cnt_q[AW-1:0];
		obuf_re    = (state_q == S_EXEC) && (func_q == FUNC_POP) && (out_cnt_q != '0);
		obuf_raddr = out_dec[AW-1:0];
	end

	// stack memories
	always_ff @(posedge clk) begin
		if (ibuf_we) begin
			ibuf[ibuf_waddr] <= value_q;
		end
		if (ibuf_re) begin
			ird_q <= ibuf[ibuf_raddr];
		end
	end

	always_ff @(posedge clk) begin
		if (obuf_we) begin
			obuf[obuf_waddr] <= ird_q;
		end
		if (obuf_re) begin
			ord_q <= obuf[obuf_raddr];
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (cmd_acc) begin
			func_q  <= cmd.func;
			value_q <= cmd.value;
		end
		if (state_q == S_EXEC) begin
			popped_q <= '0;
			case (func_q)
				FUNC_PUSH:  status_q <= in_full ? ST_FULL : ST_OK;
				FUNC_POP:   status_q <= q_empty ? ST_EMPTY_POP : ST_OK;
				FUNC_CHECK: status_q <= q_empty ? ST_OK : ST_NOT_EMPTY;
				default:    status_q <= ST_MISMATCH;
			endcase
		end
		if (state_q == S_CMP) begin
			popped_q <= ord_q;
			status_q <= (ord_q != value_q) ? ST_MISMATCH : ST_OK;
		end
		if (rsp_load) begin
			rsp_q.status       <= status_q;
			rsp_q.popped_value <= popped_q;
			rsp_q.entry_count  <= COUNT_W'(total);
			rsp_q.all_ok       <= !(failure_q || (status_q != ST_OK));
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_cnt_q    <= '0;
			out_cnt_q   <= '0;
			failure_q   <= 1'b0;
			mv_pend_s1  <= 1'b0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (!rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (cmd_acc) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					case (func_q)
						FUNC_PUSH: begin
							state_q <= S_RESP;
							if (!in_full) begin
								in_cnt_q <= in_cnt_q + CW'(1);
							end
						end
						FUNC_POP: begin
							if (q_empty) begin
								state_q <= S_RESP;
							end else if (out_cnt_q == '0) begin
								state_q <= S_XFER;
							end else begin
								out_cnt_q <= out_dec;
								state_q   <= S_CMP;
							end
						end
						default: state_q <= S_RESP;
					endcase
				end
				S_XFER: begin
					mv_pend_s1 <= ibuf_re;
					if (ibuf_re) begin
						in_cnt_q <= in_dec;
					end
					if (obuf_we) begin
						out_cnt_q <= out_cnt_q + CW'(1);
					end
					if ((in_cnt_q == '0) && !mv_pend_s1) begin
						state_q <= S_EXEC;
					end
				end
				S_CMP: begin
					state_q <= S_RESP;
				end
				S_RESP: begin
					if (rsp_load) begin
						failure_q <= failure_q || (status_q != ST_OK);
						state_q   <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	a_in_cnt_range: assert property (@(posedge clk) disable iff (!arst_n)
		in_cnt_q <= CW'(STACK_DEPTH) && out_cnt_q <= CW'(STACK_DEPTH))
		else $error("stack count beyond depth");

	a_xfer_conserve: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XFER && $past(state_q) == S_XFER) |->
		({1'b0, in_cnt_q} + {1'b0, out_cnt_q} + (CW+1)'(mv_pend_s1)) ==
		$past({1'b0, in_cnt_q} + {1'b0, out_cnt_q} + (CW+1)'(mv_pend_s1)))
		else $error("transfer lost or duplicated an entry");

	a_xfer_start_empty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_XFER && $past(state_q) == S_EXEC) |-> (out_cnt_q == '0 && !mv_pend_s1))
		else $error("transfer started on a non-empty outbound stack");

	a_rsp_from_resp: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_valid_q) |-> $past(state_q) == S_RESP)
		else $error("response raised outside the result state");

	a_no_push_in_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		ibuf_re |-> !ibuf_we && !obuf_re)
		else $error("memory access collides with a transfer");

endmodule
